/* rtl/buddy_page_allocator_assert.svh */
// ---------------------------------------------------------------------------
// Buddy page allocator assertion macros
// Concurrent assertion wrappers that can be compiled out with ASSERT_OFF.
// ---------------------------------------------------------------------------
`ifndef BUDDY_PAGE_ALLOCATOR_ASSERT_SVH
`define BUDDY_PAGE_ALLOCATOR_ASSERT_SVH
`ifndef ASSERT_OFF
// Checks a property on every rising clock edge outside reset.
`define BPA_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("buddy allocator assertion failed");
// Checks that a condition never holds outside reset.
`define BPA_ASSERT_NEVER(lbl, clk, rstn, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
    else $error("buddy allocator forbidden condition");
`else
`define BPA_ASSERT(lbl, clk, rstn, prop)
`define BPA_ASSERT_NEVER(lbl, clk, rstn, cond)
`endif
`endif

/* rtl/bpa_pkg.sv */
// ---------------------------------------------------------------------------
// Buddy page allocator package
// Default sizes, operation and status codes, and the order computation.
// ---------------------------------------------------------------------------
package bpa_pkg;

  localparam int PAGE_FRAMES_DEF = 4096;
  localparam int TOP_ORDER_DEF   = 10;

  localparam int CNT_W = 13;
  localparam int FRM_W = 12;
  localparam int ORD_W = 5;

  typedef enum logic [1:0] {
    OP_ALLOC = 2'd0,
    OP_FREE  = 2'd1,
    OP_INIT  = 2'd2,
    OP_NONE  = 2'd3
  } opcode_e;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_ZERO = 2'd1,
    ST_BIG  = 2'd2,
    ST_OOM  = 2'd3
  } status_e;

  localparam logic [2:0] REG_FIRST_USABLE = 3'd0;

  // Smallest order whose block holds the given page count.
  function automatic logic [ORD_W-1:0] order_of(input logic [CNT_W-1:0] count);
    logic [ORD_W-1:0] o;
    o = ORD_W'(CNT_W);
    for (int k = CNT_W - 1; k >= 0; k--) begin
      if ({1'b0, count} <= ((CNT_W+1)'(1) << k)) begin
        o = ORD_W'(k);
      end
    end
    return o;
  endfunction

endpackage

/* rtl/bpa_ram.sv */
// ---------------------------------------------------------------------------
// Buddy page allocator RAM
// Simple dual-port memory with one write port and one registered read port.
// ---------------------------------------------------------------------------
module bpa_ram #(
  parameter int DEPTH = 4096,
  parameter int DW    = 5,
  parameter int AW    = 12
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [DW-1:0] wdata_i,
  input  logic [AW-1:0] raddr_i,
  output logic [DW-1:0] rdata_o
);

  logic [DW-1:0] mem_q [DEPTH];

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule

/* rtl/buddy_page_allocator.sv */
// ---------------------------------------------------------------------------
// Buddy page allocator
// Sequencer over per-frame metadata and link memories with LIFO free lists.
// ---------------------------------------------------------------------------
// Usage: drive opcode_i, page_count_i and page_frame_i with start_i high; the
// word is taken at a clock edge where busy_o is low. busy_o stays high until
// the result is ready; done_o then goes high for exactly one cycle with
// status_o and alloc_frame_o valid, in a cycle in which the next word may start.
// The receiver cannot stall the result. One word is handled at a time.
// Steps per word while busy_o is high:
//   allocate: scan up from the requested order to a non-empty list (out of
//   memory past TOP_ORDER), pop its head, then split down to the request.
//   free: per merged level, read the buddy's metadata and walk its list to
//   unlink it; stop at a buddy not free at that order, at the top order or
//   past the last frame, then push the block. initialize: clear every frame,
//   then release each frame from first_usable_page up. Error and ignored
//   words: busy_o stays low; the result follows in the next cycle.
// After reset the block runs a clearing pass over every frame of the
// metadata and link memories with busy_o high; configuration writes are
// still taken. first_usable_page sits at byte address 0 of the APB port.
// ---------------------------------------------------------------------------
module buddy_page_allocator #(
  parameter int PAGE_FRAMES = bpa_pkg::PAGE_FRAMES_DEF,
  parameter int TOP_ORDER   = bpa_pkg::TOP_ORDER_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [1:0]  opcode_i,
  input  logic [12:0] page_count_i,
  input  logic [11:0] page_frame_i,
  output logic        done_o,
  output logic [1:0]  status_o,
  output logic [11:0] alloc_frame_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int AW   = (PAGE_FRAMES > 1) ? $clog2(PAGE_FRAMES) : 1;
  localparam int LW   = $clog2(PAGE_FRAMES + 1);
  localparam int OW   = (TOP_ORDER > 1) ? $clog2(TOP_ORDER + 1) : 1;
  localparam int BWA  = (AW > TOP_ORDER) ? AW : TOP_ORDER;
  localparam int BW   = ((BWA + 2) > 14) ? (BWA + 2) : 14;
  localparam int OFW  = bpa_pkg::ORD_W;
  localparam int MW   = OW + 1;
  localparam int NH   = TOP_ORDER + 1;

  localparam logic [BW-1:0]  NB   = BW'(PAGE_FRAMES);
  localparam logic [LW-1:0]  NIL  = LW'(PAGE_FRAMES);
  localparam logic [OFW-1:0] TOPO = OFW'(TOP_ORDER);
  localparam logic [AW-1:0]  LAST = AW'(PAGE_FRAMES - 1);
  localparam logic REG_IDX0 = bpa_pkg::REG_FIRST_USABLE[2];

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_CLEAR    = 4'd1;
  localparam logic [3:0] S_REL_CHK  = 4'd2;
  localparam logic [3:0] S_REL_META = 4'd3;
  localparam logic [3:0] S_UL_LOOK  = 4'd4;
  localparam logic [3:0] S_UL_WAIT  = 4'd5;
  localparam logic [3:0] S_REL_MRG  = 4'd6;
  localparam logic [3:0] S_REL_PUSH = 4'd7;
  localparam logic [3:0] S_AL_SCAN  = 4'd8;
  localparam logic [3:0] S_AL_POP   = 4'd9;
  localparam logic [3:0] S_AL_SPLIT = 4'd10;

  logic [3:0]     state_q, state_d;
  logic           init_q, init_d;
  logic [AW-1:0]  clr_q, clr_d;
  logic [BW-1:0]  f_q, f_d, b_q, b_d, i_q, i_d;
  logic [OFW-1:0] o_q, o_d, t_q, t_d, c_q, c_d;
  logic [LW-1:0]  prev_q, prev_d, cur_q, cur_d, n_q, n_d;
  logic [AW-1:0]  p_q, p_d;
  logic [LW-1:0]  head_q [NH];
  logic           done_q, done_d;
  logic [1:0]     status_q, status_d;
  logic [11:0]    frame_q, frame_d;
  logic [12:0]    fup_q;

  logic [OFW-1:0] ord, cn;
  logic [BW-1:0]  bw, sb;
  logic [OW-1:0]  hidx;
  logic [LW-1:0]  hrd;
  logic           head_we, head_clr;
  logic [LW-1:0]  head_wd;

  logic           meta_we, link_we;
  logic [AW-1:0]  meta_wa, meta_ra, link_wa, link_ra;
  logic [MW-1:0]  meta_wd, meta_rd;
  logic [LW-1:0]  link_wd, link_rd;

  // Configuration port.
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_IDX0) ? {19'd0, fup_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fup_q <= '0;
    end else if (psel && penable && pwrite && pready && paddr[2] == REG_IDX0) begin
      fup_q <= pwdata[12:0];
    end
  end

  // Memories for per-frame metadata {free, order} and next links.
  bpa_ram #(.DEPTH(PAGE_FRAMES), .DW(MW), .AW(AW)) u_meta (
    .clk_i(clk_i), .we_i(meta_we), .waddr_i(meta_wa), .wdata_i(meta_wd),
    .raddr_i(meta_ra), .rdata_o(meta_rd)
  );

  bpa_ram #(.DEPTH(PAGE_FRAMES), .DW(LW), .AW(AW)) u_link (
    .clk_i(clk_i), .we_i(link_we), .waddr_i(link_wa), .wdata_i(link_wd),
    .raddr_i(link_ra), .rdata_o(link_rd)
  );

  // Shared helpers: order of the count, buddy and split addresses, head select.
  assign ord = bpa_pkg::order_of(page_count_i);
  assign cn  = c_q - OFW'(1);
  assign bw  = f_q ^ (BW'(1) << o_q);
  assign sb  = BW'(p_q) + (BW'(1) << cn);

  always_comb begin
    case (state_q)
      S_AL_SCAN, S_AL_POP: hidx = c_q[OW-1:0];
      S_AL_SPLIT:          hidx = cn[OW-1:0];
      default:             hidx = o_q[OW-1:0];
    endcase
  end

  assign hrd = (32'(hidx) <= TOP_ORDER) ? head_q[hidx] : NIL;

  // Sequencer.
  always_comb begin
    state_d  = state_q;
    init_d   = init_q;
    clr_d    = clr_q;
    f_d      = f_q;
    b_d      = b_q;
    i_d      = i_q;
    o_d      = o_q;
    t_d      = t_q;
    c_d      = c_q;
    prev_d   = prev_q;
    cur_d    = cur_q;
    n_d      = n_q;
    p_d      = p_q;
    done_d   = 1'b0;
    status_d = status_q;
    frame_d  = frame_q;
    head_we  = 1'b0;
    head_clr = 1'b0;
    head_wd  = hrd;
    meta_we  = 1'b0;
    meta_wa  = f_q[AW-1:0];
    meta_wd  = '0;
    meta_ra  = bw[AW-1:0];
    link_we  = 1'b0;
    link_wa  = f_q[AW-1:0];
    link_wd  = hrd;
    link_ra  = cur_q[AW-1:0];

    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          status_d = bpa_pkg::ST_OK;
          frame_d  = '0;
          case (opcode_i)
            bpa_pkg::OP_ALLOC: begin
              if (page_count_i == '0) begin
                status_d = bpa_pkg::ST_ZERO;
                done_d   = 1'b1;
              end else if (ord > TOPO) begin
                status_d = bpa_pkg::ST_BIG;
                done_d   = 1'b1;
              end else begin
                c_d     = ord;
                t_d     = ord;
                state_d = S_AL_SCAN;
              end
            end
            bpa_pkg::OP_FREE: begin
              if (ord > TOPO) begin
                status_d = bpa_pkg::ST_BIG;
                done_d   = 1'b1;
              end else if (BW'(page_frame_i) >= NB) begin
                done_d = 1'b1;
              end else begin
                f_d     = BW'(page_frame_i);
                o_d     = ord;
                init_d  = 1'b0;
                state_d = S_REL_CHK;
              end
            end
            bpa_pkg::OP_INIT: begin
              head_clr = 1'b1;
              clr_d    = '0;
              init_d   = 1'b1;
              state_d  = S_CLEAR;
            end
            default: begin
              done_d = 1'b1;
            end
          endcase
        end
      end

      // Sweep every frame to used, order zero, empty link.
      S_CLEAR: begin
        meta_we = 1'b1;
        meta_wa = clr_q;
        meta_wd = '0;
        link_we = 1'b1;
        link_wa = clr_q;
        link_wd = NIL;
        clr_d   = clr_q + AW'(1);
        if (clr_q == LAST) begin
          if (!init_q) begin
            state_d = S_IDLE;
          end else if (BW'(fup_q) >= NB) begin
            done_d  = 1'b1;
            state_d = S_IDLE;
          end else begin
            i_d     = BW'(fup_q);
            f_d     = BW'(fup_q);
            o_d     = '0;
            state_d = S_REL_CHK;
          end
        end
      end

      // Test whether the buddy may merge; its metadata is read here.
      S_REL_CHK: begin
        if (o_q >= TOPO || bw >= NB) begin
          state_d = S_REL_PUSH;
        end else begin
          b_d     = bw;
          state_d = S_REL_META;
        end
      end

      S_REL_META: begin
        if (!meta_rd[MW-1] || meta_rd[OW-1:0] != o_q[OW-1:0]) begin
          state_d = S_REL_PUSH;
        end else begin
          prev_d  = NIL;
          cur_d   = hrd;
          n_d     = '0;
          state_d = S_UL_LOOK;
        end
      end

      // Walk the list of this order looking for the buddy.
      S_UL_LOOK: begin
        if (n_q >= NIL || cur_q >= NIL) begin
          state_d = S_REL_MRG;
        end else begin
          state_d = S_UL_WAIT;
        end
      end

      S_UL_WAIT: begin
        if (BW'(cur_q) == b_q) begin
          if (prev_q == NIL) begin
            head_we = 1'b1;
            head_wd = link_rd;
          end else begin
            link_we = 1'b1;
            link_wa = prev_q[AW-1:0];
            link_wd = link_rd;
          end
          state_d = S_REL_MRG;
        end else begin
          prev_d  = cur_q;
          cur_d   = link_rd;
          n_d     = n_q + LW'(1);
          state_d = S_UL_LOOK;
        end
      end

      S_REL_MRG: begin
        meta_we = 1'b1;
        meta_wa = b_q[AW-1:0];
        meta_wd = {1'b0, o_q[OW-1:0]};
        if (b_q < f_q) begin
          f_d = b_q;
        end
        o_d     = o_q + OFW'(1);
        state_d = S_REL_CHK;
      end

      // Push the merged block onto its list.
      S_REL_PUSH: begin
        meta_we = 1'b1;
        meta_wd = {1'b1, o_q[OW-1:0]};
        link_we = 1'b1;
        head_we = 1'b1;
        head_wd = LW'(f_q);
        if (init_q && (i_q + BW'(1)) < NB) begin
          i_d     = i_q + BW'(1);
          f_d     = i_q + BW'(1);
          o_d     = '0;
          state_d = S_REL_CHK;
        end else begin
          done_d  = 1'b1;
          state_d = S_IDLE;
        end
      end

      // Find the smallest non-empty list at or above the order.
      S_AL_SCAN: begin
        link_ra = hrd[AW-1:0];
        if (c_q > TOPO) begin
          status_d = bpa_pkg::ST_OOM;
          done_d   = 1'b1;
          state_d  = S_IDLE;
        end else if (hrd >= NIL) begin
          c_d = c_q + OFW'(1);
        end else begin
          p_d     = hrd[AW-1:0];
          state_d = S_AL_POP;
        end
      end

      S_AL_POP: begin
        head_we = 1'b1;
        head_wd = link_rd;
        state_d = S_AL_SPLIT;
      end

      // Split down to the requested order, one half per cycle.
      S_AL_SPLIT: begin
        if (c_q > t_q) begin
          if (sb < NB) begin
            meta_we = 1'b1;
            meta_wa = sb[AW-1:0];
            meta_wd = {1'b1, cn[OW-1:0]};
            link_we = 1'b1;
            link_wa = sb[AW-1:0];
            head_we = 1'b1;
            head_wd = LW'(sb);
          end
          c_d = cn;
        end else begin
          meta_we = 1'b1;
          meta_wa = p_q;
          meta_wd = {1'b0, t_q[OW-1:0]};
          frame_d = 12'(p_q);
          done_d  = 1'b1;
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      init_q  <= 1'b0;
      clr_q   <= '0;
      done_q  <= 1'b0;
      for (int k = 0; k < NH; k++) begin
        head_q[k] <= NIL;
      end
    end else begin
      state_q <= state_d;
      init_q  <= init_d;
      clr_q   <= clr_d;
      done_q  <= done_d;
      if (head_clr) begin
        for (int k = 0; k < NH; k++) begin
          head_q[k] <= NIL;
        end
      end else if (head_we) begin
        head_q[hidx] <= head_wd;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    f_q      <= f_d;
    b_q      <= b_d;
    i_q      <= i_d;
    o_q      <= o_d;
    t_q      <= t_d;
    c_q      <= c_d;
    prev_q   <= prev_d;
    cur_q    <= cur_d;
    n_q      <= n_d;
    p_q      <= p_d;
    status_q <= status_d;
    frame_q  <= frame_d;
  end

  assign busy_o        = (state_q != S_IDLE);
  assign done_o        = done_q;
  assign status_o      = status_q;
  assign alloc_frame_o = frame_q;

  // Assertions.
`include "buddy_page_allocator_assert.svh"

  `BPA_ASSERT(a_start_busy, clk_i, rst_ni, (start_i && !busy_o) |=> (busy_o || done_o))
  `BPA_ASSERT_NEVER(a_frame_zero, clk_i, rst_ni, done_o && status_o != bpa_pkg::ST_OK && alloc_frame_o != '0)
  `BPA_ASSERT_NEVER(a_done_busy, clk_i, rst_ni, done_o && busy_o)

endmodule

/* tb/buddy_page_allocator_test.sv */
// ----------------------------------------------------------------------------
// Buddy page allocator testbench
// Sends allocate, free and initialize words through the command handshake and
// checks every result word against a predictor that keeps its own copy of
// the free lists and the per-frame state. The first usable page register is
// written over the APB port between phases, its extremes included.
// ----------------------------------------------------------------------------
module buddy_page_allocator_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NFRAMES  = 4096;
  localparam int MAXORD   = 10;
  localparam int NIL      = NFRAMES;
  localparam int WD_LIMIT = 400000;

  typedef struct packed {
    bpa_pkg::status_e st;
    logic [11:0]      frame;
  } alloc_result_t;

  typedef struct packed {
    logic [11:0] frame;
    logic [12:0] count;
  } live_block_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start_i = 1'b0;
  logic        busy_o;
  logic [1:0]  opcode_i = 2'd0;
  logic [12:0] page_count_i = 13'd0;
  logic [11:0] page_frame_i = 12'd0;
  logic        done_o;
  logic [1:0]  status_o;
  logic [11:0] alloc_frame_o;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = 3'd0;
  logic [31:0] pwdata = 32'd0;
  logic [31:0] prdata;
  logic        pready;

  // Predictor state: free flags, block orders, links and list heads.
  logic        pg_free [NFRAMES];
  logic [3:0]  pg_order [NFRAMES];
  logic [12:0] pg_link [NFRAMES];
  logic [12:0] list_top [MAXORD+1];
  logic [12:0] first_page;

  alloc_result_t result_q[$];
  live_block_t   live_q[$];
  int            errors = 0;
  int            idle_cycles = 0;
  bit            idle_on = 1'b1;

  buddy_page_allocator u_top (
    .clk_i, .rst_ni, .start_i, .busy_o, .opcode_i, .page_count_i, .page_frame_i,
    .done_o, .status_o, .alloc_frame_o, .psel, .penable, .pwrite, .paddr,
    .pwdata, .prdata, .pready
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------- predictor
  function automatic int pages_to_order(logic [12:0] count);
    int size;
    int o;
    size = 1;
    o = 0;
    while (size < count) begin
      size = size * 2;
      o++;
    end
    return o;
  endfunction

  function automatic void push_free(int o, int f);
    pg_free[f] = 1'b1;
    pg_order[f] = 4'(o);
    pg_link[f] = list_top[o];
    list_top[o] = 13'(f);
  endfunction

  function automatic void unlink_free(int o, int f);
    int prev;
    int cur;
    prev = NIL;
    cur = list_top[o];
    for (int n = 0; n < NFRAMES && cur < NIL; n++) begin
      if (cur == f) begin
        if (prev == NIL) list_top[o] = pg_link[cur];
        else pg_link[prev] = pg_link[cur];
        return;
      end
      prev = cur;
      cur = pg_link[cur];
    end
  endfunction

  function automatic void merge_and_free(int f, int o);
    int b;
    while (o < MAXORD) begin
      b = f ^ (1 << o);
      if (b >= NIL) break;
      if (!pg_free[b] || pg_order[b] != o) break;
      unlink_free(o, b);
      pg_free[b] = 1'b0;
      if (b < f) f = b;
      o++;
    end
    push_free(o, f);
  endfunction

  function automatic alloc_result_t predict_word(bpa_pkg::opcode_e op, logic [12:0] count,
                                                 logic [11:0] frame);
    alloc_result_t r;
    int t;
    int c;
    int p;
    r.st = bpa_pkg::ST_OK;
    r.frame = '0;
    case (op)
      bpa_pkg::OP_ALLOC: begin
        if (count == 0) begin
          r.st = bpa_pkg::ST_ZERO;
        end else begin
          t = pages_to_order(count);
          if (t > MAXORD) begin
            r.st = bpa_pkg::ST_BIG;
          end else begin
            c = t;
            while (c <= MAXORD && list_top[c] >= NIL) c++;
            if (c > MAXORD) begin
              r.st = bpa_pkg::ST_OOM;
            end else begin
              p = list_top[c];
              list_top[c] = pg_link[p];
              pg_free[p] = 1'b0;
              while (c > t) begin
                c--;
                if (p + (1 << c) < NIL) push_free(c, p + (1 << c));
              end
              pg_order[p] = 4'(t);
              r.frame = 12'(p);
            end
          end
        end
      end
      bpa_pkg::OP_FREE: begin
        t = pages_to_order(count);
        if (t > MAXORD) r.st = bpa_pkg::ST_BIG;
        else merge_and_free(frame, t);
      end
      bpa_pkg::OP_INIT: begin
        for (int i = 0; i <= MAXORD; i++) list_top[i] = 13'(NIL);
        for (int i = 0; i < NFRAMES; i++) begin
          pg_free[i] = 1'b0;
          pg_order[i] = '0;
          pg_link[i] = 13'(NIL);
        end
        for (int i = first_page; i < NFRAMES; i++) merge_and_free(i, 0);
      end
      default: ;
    endcase
    return r;
  endfunction

  // ---------------------------------------------------------------- drivers
  // Sends one word; start stays high after acceptance unless the next call
  // idles first.
  task automatic send_word(bpa_pkg::opcode_e op, logic [12:0] count, logic [11:0] frame);
    alloc_result_t r;
    while (idle_on && $urandom_range(99) < 29) begin
      start_i <= 1'b0;
      @(posedge clk_i);
    end
    start_i <= 1'b1;
    opcode_i <= op;
    page_count_i <= count;
    page_frame_i <= frame;
    do @(posedge clk_i); while (busy_o);
    r = predict_word(op, count, frame);
    result_q.push_back(r);
    if (op == bpa_pkg::OP_ALLOC && r.st == bpa_pkg::ST_OK)
      live_q.push_back('{frame: r.frame, count: count});
  endtask

  task automatic drain();
    start_i <= 1'b0;
    @(posedge clk_i);
    while (result_q.size() != 0) @(posedge clk_i);
  endtask

  // Writes the first usable page register through an APB setup phase and an access phase.
  task automatic write_first_page(logic [12:0] value);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= 3'(bpa_pkg::REG_FIRST_USABLE * 4);
    pwdata <= 32'(value);
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    first_page = value;
  endtask

  // ---------------------------------------------------------------- checker
  always @(posedge clk_i) begin
    alloc_result_t e;
    if (rst_ni && done_o) begin
      if (result_q.size() == 0) begin
        $display("%0t: unexpected result word: expected none, actual status %0d frame %0d",
                 $realtime, status_o, alloc_frame_o);
        errors++;
      end else begin
        e = result_q.pop_front();
        if (status_o !== e.st) begin
          $display("%0t: status mismatch: expected %0d, actual %0d",
                   $realtime, e.st, status_o);
          errors++;
        end
        if (alloc_frame_o !== e.frame) begin
          $display("%0t: alloc_frame mismatch: expected %0d, actual %0d",
                   $realtime, e.frame, alloc_frame_o);
          errors++;
        end
      end
    end
  end

  // The watchdog restarts its count on every accepted word or result.
  always @(posedge clk_i) begin
    if ((start_i && !busy_o) || done_o) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WD_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // ---------------------------------------------------------------- tests
  function automatic logic [12:0] random_count();
    int k;
    k = $urandom_range(99);
    if (k < 70) return 13'($urandom_range(8, 1));
    if (k < 95) return 13'($urandom_range(1024, 1));
    return 13'($urandom_range(4096, 0));
  endfunction

  // Well-formed allocate and free traffic, with some noise words mixed in.
  task automatic test_random_traffic(int n);
    int k;
    int idx;
    live_block_t blk;
    for (int i = 0; i < n; i++) begin
      k = $urandom_range(99);
      if (k < 48) begin
        send_word(bpa_pkg::OP_ALLOC, random_count(), 12'($urandom));
      end else if (k < 92 && live_q.size() != 0) begin
        idx = $urandom_range(live_q.size() - 1);
        blk = live_q[idx];
        live_q.delete(idx);
        send_word(bpa_pkg::OP_FREE, blk.count, blk.frame);
      end else begin
        send_word(bpa_pkg::opcode_e'($urandom_range(3)), 13'($urandom_range(4096)),
                  12'($urandom));
      end
    end
    drain();
  endtask

  task automatic run_phase(logic [12:0] fp, int n);
    write_first_page(fp);
    live_q.delete();
    send_word(bpa_pkg::OP_INIT, 13'($urandom), 12'($urandom));
    test_random_traffic(n);
  endtask

  // Extremes, every operation and the special cases, in a short sequence.
  task automatic test_directed();
    send_word(bpa_pkg::OP_ALLOC, 13'd1, 12'd0);
    send_word(bpa_pkg::OP_NONE, 13'h1FFF, 12'hFFF);
    send_word(bpa_pkg::OP_FREE, 13'd0, 12'd7);
    send_word(bpa_pkg::OP_INIT, 13'd0, 12'd0);
    send_word(bpa_pkg::OP_ALLOC, 13'd0, 12'd0);
    send_word(bpa_pkg::OP_ALLOC, 13'd4096, 12'd0);
    send_word(bpa_pkg::OP_ALLOC, 13'd1025, 12'd0);
    send_word(bpa_pkg::OP_ALLOC, 13'd1024, 12'd0);
    send_word(bpa_pkg::OP_ALLOC, 13'd1, 12'd0);
    send_word(bpa_pkg::OP_ALLOC, 13'd3, 12'd0);
    send_word(bpa_pkg::OP_FREE, 13'd4096, 12'd0);
    send_word(bpa_pkg::OP_FREE, 13'd0, 12'hFFF);
    send_word(bpa_pkg::OP_FREE, 13'd2, 12'd1027);
    send_word(bpa_pkg::OP_FREE, 13'd1, 12'd1024);
    send_word(bpa_pkg::OP_FREE, 13'd1, 12'd1024);
    send_word(bpa_pkg::OP_ALLOC, 13'd1, 12'd0);
    send_word(bpa_pkg::OP_ALLOC, 13'd1, 12'd0);
    for (int i = 0; i < 5; i++) send_word(bpa_pkg::OP_ALLOC, 13'd1024, 12'd0);
    send_word(bpa_pkg::OP_FREE, 13'd1024, 12'd0);
    send_word(bpa_pkg::OP_FREE, 13'd512, 12'd3584);
    drain();
  endtask

  initial begin
    for (int i = 0; i <= MAXORD; i++) list_top[i] = 13'(NIL);
    for (int i = 0; i < NFRAMES; i++) begin
      pg_free[i] = 1'b0;
      pg_order[i] = '0;
      pg_link[i] = '0;
    end
    first_page = '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    write_first_page(13'd0);
    test_directed();
    run_phase(13'd4096, 20);
    run_phase(13'd4095, 30);
    run_phase(13'($urandom_range(4095)), 200);
    idle_on = 1'b0;
    run_phase(13'd0, 250);
    idle_on = 1'b1;
    run_phase(13'd1000, 150);
    run_phase(13'd0, 230);
    repeat (50) @(posedge clk_i);
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

/* filelist.f */
+incdir+rtl
rtl/bpa_pkg.sv
rtl/bpa_ram.sv
rtl/buddy_page_allocator.sv
tb/buddy_page_allocator_test.sv
